@@ rtl/core/rfa_pkg.sv @@
// Shared opcodes and controller/datapath command types for the fraction ALU.
package rfa_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_LT  = 3'd5;
  localparam logic [2:0] OP_GT  = 3'd6;

  localparam logic [1:0] MSEL_P1 = 2'd0;
  localparam logic [1:0] MSEL_P2 = 2'd1;
  localparam logic [1:0] MSEL_PD = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic gcd_done;
  } sts_t;

endpackage

@@ rtl/core/rfa_in_if.sv @@
// Input word channel: opcode and two fractions.
interface rfa_in_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ rtl/core/rfa_out_if.sv @@
// Result word channel: reduced fraction and compare flag.
interface rfa_out_if #(parameter int W = 16) ();
  logic                  valid;
  logic                  ready;
  logic signed [2*W:0]   res_num;
  logic signed [2*W-1:0] res_den;
  logic                  cmp_true;

  modport source (output valid, res_num, res_den, cmp_true, input ready);
  modport sink   (input valid, res_num, res_den, cmp_true, output ready);
endinterface

@@ rtl/core/rfa_ctrl.sv @@
// Sequencer for the fraction ALU: multiply, sum, gcd, divide, deliver.
module rfa_ctrl #(
  parameter int W = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rfa_pkg::sts_t sts,
  output rfa_pkg::cmd_t cmd
);

  localparam int MW = 2 * W;
  localparam int CW = $clog2(MW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_CHK, S_GCD, S_DIV, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    ov_nxt    = ov_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt_r[1:0];
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r[1:0] == rfa_pkg::MSEL_PD) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.skip) begin
          state_nxt = S_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == CW'(MW - 1) |=> state_r == S_DONE)
    else $error("divide did not finish after full width");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> ov_r)
    else $error("result word lost at output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !ov_r || out_ready)
    else $error("output register overwritten while held");

endmodule

@@ rtl/core/rfa_dpath.sv @@
// Datapath: shared multiplier, sign-magnitude sum, binary gcd, two restoring dividers.
module rfa_dpath #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rfa_pkg::cmd_t         cmd,
  output rfa_pkg::sts_t         sts,
  input  logic [2:0]            opcode,
  input  logic signed [W-1:0]   a_num,
  input  logic signed [W-1:0]   a_den,
  input  logic signed [W-1:0]   b_num,
  input  logic signed [W-1:0]   b_den,
  output logic signed [2*W:0]   res_num,
  output logic signed [2*W-1:0] res_den,
  output logic                  cmp_true
);

  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW);

  // sign-magnitude view of the inputs
  logic         an_s, ad_s, bn_s, bd_s, nn_s, nd_s;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         eq_c;

  always_comb begin
    an_s = a_num[W-1];
    an_m = an_s ? W'(-a_num) : W'(a_num);
    bn_s = b_num[W-1];
    bn_m = bn_s ? W'(-b_num) : W'(b_num);
    ad_s = a_den[W-1];
    ad_m = ad_s ? W'(-a_den) : W'(a_den);
    if (ad_m == '0) begin
      ad_m = W'(1);
    end
    bd_s = b_den[W-1];
    bd_m = bd_s ? W'(-b_den) : W'(b_den);
    if (bd_m == '0) begin
      bd_m = W'(1);
    end
    // negated b with its denominator sign moved onto the numerator
    nn_s = (bn_m != '0) && (!bn_s ^ bd_s);
    nd_s = (bn_m == '0) && bd_s;
    eq_c = (an_m == bn_m) && (ad_m == bd_m) && ((an_s ^ ad_s) == (bn_s ^ bd_s));
  end

  logic [2:0]   op_r;
  logic         eq_r;
  logic         x1_s_r, y1_s_r, x2_s_r, y2_s_r, x3_s_r, y3_s_r;
  logic [W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      eq_r <= eq_c;
      case (opcode) inside
        rfa_pkg::OP_SUB, rfa_pkg::OP_LT, rfa_pkg::OP_GT: begin
          {x1_s_r, x1_r} <= {an_s, an_m};  {y1_s_r, y1_r} <= {nd_s, bd_m};
          {x2_s_r, x2_r} <= {nn_s, bn_m};  {y2_s_r, y2_r} <= {ad_s, ad_m};
          {x3_s_r, x3_r} <= {ad_s, ad_m};  {y3_s_r, y3_r} <= {nd_s, bd_m};
        end
        rfa_pkg::OP_MUL: begin
          {x1_s_r, x1_r} <= {an_s, an_m};  {y1_s_r, y1_r} <= {bn_s, bn_m};
          {x2_s_r, x2_r} <= {1'b0, W'(0)}; {y2_s_r, y2_r} <= {1'b0, W'(0)};
          {x3_s_r, x3_r} <= {ad_s, ad_m};  {y3_s_r, y3_r} <= {bd_s, bd_m};
        end
        rfa_pkg::OP_DIV: begin
          {x1_s_r, x1_r} <= {an_s, an_m};  {y1_s_r, y1_r} <= {bd_s, bd_m};
          {x2_s_r, x2_r} <= {1'b0, W'(0)}; {y2_s_r, y2_r} <= {1'b0, W'(0)};
          {x3_s_r, x3_r} <= {ad_s, ad_m};  {y3_s_r, y3_r} <= {bn_s, bn_m};
        end
        default: begin
          {x1_s_r, x1_r} <= {an_s, an_m};  {y1_s_r, y1_r} <= {bd_s, bd_m};
          {x2_s_r, x2_r} <= {bn_s, bn_m};  {y2_s_r, y2_r} <= {ad_s, ad_m};
          {x3_s_r, x3_r} <= {ad_s, ad_m};  {y3_s_r, y3_r} <= {bd_s, bd_m};
        end
      endcase
    end
  end

  // one shared multiplier, one product per cycle
  logic [W-1:0]  mx, my;
  logic          mx_s, my_s;
  logic [MW-1:0] prod;
  logic          p1_s_r, p2_s_r, pd_s_r;
  logic [MW-1:0] p1_r, p2_r, pd_r;

  always_comb begin
    case (cmd.mul_sel)
      rfa_pkg::MSEL_P1: begin mx = x1_r; my = y1_r; mx_s = x1_s_r; my_s = y1_s_r; end
      rfa_pkg::MSEL_P2: begin mx = x2_r; my = y2_r; mx_s = x2_s_r; my_s = y2_s_r; end
      default:          begin mx = x3_r; my = y3_r; mx_s = x3_s_r; my_s = y3_s_r; end
    endcase
    prod = MW'(mx) * MW'(my);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rfa_pkg::MSEL_P1: begin p1_r <= prod; p1_s_r <= (prod != '0) && (mx_s ^ my_s); end
        rfa_pkg::MSEL_P2: begin p2_r <= prod; p2_s_r <= (prod != '0) && (mx_s ^ my_s); end
        default:          begin pd_r <= prod; pd_s_r <= (prod != '0) && (mx_s ^ my_s); end
      endcase
    end
  end

  // signed-magnitude sum of the two numerator products
  logic          n_s_r, d_s_r;
  logic [MW-1:0] n_r, d_r;
  logic          sum_s;
  logic [MW-1:0] sum_m;

  always_comb begin
    if (p1_s_r == p2_s_r) begin
      sum_m = p1_r + p2_r;
      sum_s = p1_s_r;
    end else if (p1_r >= p2_r) begin
      sum_m = p1_r - p2_r;
      sum_s = p1_s_r;
    end else begin
      sum_m = p2_r - p1_r;
      sum_s = p2_s_r;
    end
    if (sum_m == '0) begin
      sum_s = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      n_r   <= sum_m;
      n_s_r <= sum_s;
      if (pd_r == '0) begin
        d_r   <= MW'(1);
        d_s_r <= 1'b0;
      end else begin
        d_r   <= pd_r;
        d_s_r <= pd_s_r;
      end
    end
  end

  assign sts.skip = (op_r[2] == 1'b1) || (n_r == '0);

  // binary gcd: one shift or subtract per cycle
  logic [MW-1:0] gx_r, gy_r;
  logic [KW-1:0] gk_r;

  assign sts.gcd_done = (gx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gx_r <= n_r;
      gy_r <= d_r;
      gk_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
  end

  // two restoring dividers by the gcd, one quotient bit per cycle
  logic [MW-1:0] g_r, qn_r, qd_r;
  logic [MW:0]   rn_r, rd_r;
  logic [MW:0]   rn_sh, rd_sh;

  assign rn_sh = {rn_r[MW-1:0], qn_r[MW-1]};
  assign rd_sh = {rd_r[MW-1:0], qd_r[MW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g_r  <= gy_r << gk_r;
      qn_r <= n_r;
      qd_r <= d_r;
      rn_r <= '0;
      rd_r <= '0;
    end else if (cmd.div_step) begin
      if (rn_sh >= {1'b0, g_r}) begin
        rn_r <= rn_sh - {1'b0, g_r};
        qn_r <= {qn_r[MW-2:0], 1'b1};
      end else begin
        rn_r <= rn_sh;
        qn_r <= {qn_r[MW-2:0], 1'b0};
      end
      if (rd_sh >= {1'b0, g_r}) begin
        rd_r <= rd_sh - {1'b0, g_r};
        qd_r <= {qd_r[MW-2:0], 1'b1};
      end else begin
        rd_r <= rd_sh;
        qd_r <= {qd_r[MW-2:0], 1'b0};
      end
    end
  end

  // output register
  logic          cmp_c;
  logic [MW:0]   num_c;
  logic [MW-1:0] den_c;

  always_comb begin
    cmp_c = 1'b0;
    num_c = '0;
    den_c = MW'(1);
    case (op_r)
      rfa_pkg::OP_EQ: cmp_c = eq_r;
      rfa_pkg::OP_LT: cmp_c = (n_r != '0) && (n_s_r ^ d_s_r);
      rfa_pkg::OP_GT: cmp_c = (n_r != '0) && !(n_s_r ^ d_s_r);
      default: begin
        if (!sts.skip) begin
          num_c = n_s_r ? -{1'b0, qn_r} : {1'b0, qn_r};
          den_c = d_s_r ? -qd_r : qd_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num  <= num_c;
      res_den  <= den_c;
      cmp_true <= cmp_c;
    end
  end

  a_gy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |-> gy_r != '0)
    else $error("gcd operand collapsed to zero");

  a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !sts.skip |-> rn_r == '0 && rd_r == '0)
    else $error("reduction left a remainder");

  a_gcd_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_init |=> gx_r != '0 && gy_r != '0)
    else $error("gcd started on a zero operand");

endmodule

@@ rtl/core/rational_fraction_alu_core.sv @@
// Top level of the rational fraction ALU.
// Takes one word (opcode, a_num/a_den, b_num/b_den) at a time and returns one result word.
// Arithmetic opcodes form three products on a single shared WIDTH x WIDTH multiplier,
// then a binary gcd of one shift or subtract per cycle, then restoring division of the
// numerator and denominator by the gcd; compares and zero results skip the gcd and the
// division. A new word is taken while the previous result still waits in the output
// register.
module rational_fraction_alu_core #(
  parameter int WIDTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  rfa_in_if.sink            in_ch,
  rfa_out_if.source         out_ch
);

  rfa_pkg::cmd_t cmd;
  rfa_pkg::sts_t sts;

  rfa_ctrl #(.W(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfa_dpath #(.W(WIDTH)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .opcode   (in_ch.opcode),
    .a_num    (in_ch.a_num),
    .a_den    (in_ch.a_den),
    .b_num    (in_ch.b_num),
    .b_den    (in_ch.b_den),
    .res_num  (out_ch.res_num),
    .res_den  (out_ch.res_den),
    .cmp_true (out_ch.cmp_true)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the rational fraction ALU core: directed table plus random words.
`timescale 1ns / 100ps

module testbench;

  localparam int          W          = 16;
  localparam logic [2:0]  OP_SPARE   = 3'd7;
  localparam int          N_RANDOM   = 1500;
  localparam int          STALL_MAX  = 5000;
  localparam int          DRAIN_WAIT = 300;

  typedef struct {
    bit              neg;
    longint unsigned mag;
  } smag_t;

  typedef struct {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
    bit                  typed;
    logic signed [2*W:0]   num;
    logic signed [2*W-1:0] den;
    logic                  cmp;
  } fraction_op_t;

  typedef struct {
    logic signed [2*W:0]   num;
    logic signed [2*W-1:0] den;
    logic                  cmp;
  } fraction_res_t;

  logic clk;
  logic rst_n;

  rfa_in_if  #(.W(W)) in_ch ();
  rfa_out_if #(.W(W)) out_ch ();

  rational_fraction_alu_core #(.WIDTH(W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fraction_op_t  op_list[$];
  fraction_res_t pending_results[$];
  int            next_op;
  int            cycle_count;
  int            quiet_cycles;
  int            error_count;
  bit            stim_done;

  // ---------------- fraction arithmetic ----------------
  function automatic smag_t to_smag(logic [W-1:0] raw);
    smag_t r;
    r.neg = raw[W-1];
    r.mag = r.neg ? ((64'd1 << W) - raw) : raw;
    return r;
  endfunction

  function automatic smag_t to_den(logic [W-1:0] raw);
    smag_t r;
    r = to_smag(raw);
    if (r.mag == 0) begin
      r.neg = 0;
      r.mag = 1;
    end
    return r;
  endfunction

  function automatic smag_t sm_times(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_t sm_plus(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic void lowest_terms(inout smag_t n, inout smag_t d);
    longint unsigned x, y, t;
    if (d.mag == 0) begin
      d.neg = 0;
      d.mag = 1;
    end
    if (n.mag == 0) begin
      n.neg = 0;
      d.neg = 0;
      d.mag = 1;
      return;
    end
    x = n.mag;
    y = d.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    n.mag = n.mag / x;
    d.mag = d.mag / x;
  endfunction

  // a - b: negate b, then move a negative denominator sign onto the numerator
  function automatic void fraction_diff(smag_t an, smag_t ad, smag_t bn, smag_t bd,
                                        output smag_t rn, output smag_t rd);
    smag_t nn, nd;
    nn = bn;
    nd = bd;
    if (nn.mag != 0) nn.neg = !nn.neg;
    if (nn.mag != 0 && nd.neg) begin
      nn.neg = !nn.neg;
      nd.neg = 0;
    end
    rn = sm_plus(sm_times(an, nd), sm_times(nn, ad));
    rd = sm_times(ad, nd);
    lowest_terms(rn, rd);
  endfunction

  function automatic fraction_res_t fraction_result(fraction_op_t op);
    fraction_res_t res;
    smag_t an, ad, bn, bd, rn, rd;
    bit cmp, negative;
    an = to_smag(op.a_num);
    ad = to_den(op.a_den);
    bn = to_smag(op.b_num);
    bd = to_den(op.b_den);
    rn = '{0, 0};
    rd = '{0, 1};
    cmp = 0;
    case (op.opcode) inside
      rfa_pkg::OP_ADD: begin
        rn = sm_plus(sm_times(an, bd), sm_times(bn, ad));
        rd = sm_times(ad, bd);
        lowest_terms(rn, rd);
      end
      rfa_pkg::OP_SUB: fraction_diff(an, ad, bn, bd, rn, rd);
      rfa_pkg::OP_MUL: begin
        rn = sm_times(an, bn);
        rd = sm_times(ad, bd);
        lowest_terms(rn, rd);
      end
      rfa_pkg::OP_DIV: begin
        rn = sm_times(an, bd);
        rd = sm_times(ad, bn);
        lowest_terms(rn, rd);
      end
      rfa_pkg::OP_EQ: begin
        cmp = (an.mag == bn.mag) && (ad.mag == bd.mag) &&
              ((an.neg != ad.neg) == (bn.neg != bd.neg));
      end
      rfa_pkg::OP_LT, rfa_pkg::OP_GT: begin
        smag_t dn, dd;
        fraction_diff(an, ad, bn, bd, dn, dd);
        negative = dn.neg != dd.neg;
        if (dn.mag != 0) cmp = (op.opcode == rfa_pkg::OP_LT) ? negative : !negative;
        rn = '{0, 0};
        rd = '{0, 1};
      end
      default: ;
    endcase
    res.num = (2*W+1)'(rn.neg ? -rn.mag : rn.mag);
    res.den = (2*W)'(rd.neg ? -rd.mag : rd.mag);
    res.cmp = cmp;
    return res;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [W-1:0] rand_part(int sel);
    case (sel)
      0:       return 16'($signed($urandom_range(40)) - 20);
      1:       return 16'($urandom_range(2) == 0 ? 16'h8000 : 16'h7FFF);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [2:0] opc, int an, int ad, int bn, int bd,
                         bit typed = 0, int num = 0, int den = 1, bit cmp = 0);
    fraction_op_t r;
    r.opcode = opc;
    r.a_num  = W'(an);
    r.a_den  = W'(ad);
    r.b_num  = W'(bn);
    r.b_den  = W'(bd);
    r.typed  = typed;
    r.num    = (2*W+1)'(num);
    r.den    = (2*W)'(den);
    r.cmp    = cmp;
    op_list.push_back(r);
  endtask

  initial begin
    fraction_op_t r;
    int sel;
    // directed table: typed results where they are plain, the rest predicted
    add_row(rfa_pkg::OP_ADD, 1, 2, 1, 2, 1, 1, 1, 0);
    add_row(rfa_pkg::OP_ADD, 1, 0, 1, 0, 1, 2, 1, 0);
    add_row(rfa_pkg::OP_MUL, 0, 5, 3, 7, 1, 0, 1, 0);
    add_row(rfa_pkg::OP_MUL, -32768, 1, -32768, 1, 1, 1 << 30, 1, 0);
    add_row(rfa_pkg::OP_DIV, 3, 4, 0, 5, 1, 15, 1, 0);
    add_row(rfa_pkg::OP_SUB, 1, 1, 0, -3, 1, -1, -1, 0);
    add_row(rfa_pkg::OP_EQ, 1, 2, -1, -2, 1, 0, 1, 1);
    add_row(rfa_pkg::OP_EQ, 1, 2, 2, 4, 1, 0, 1, 0);
    add_row(rfa_pkg::OP_LT, 1, 3, 1, 2, 1, 0, 1, 1);
    add_row(rfa_pkg::OP_GT, 1, 3, 1, 2, 1, 0, 1, 0);
    add_row(rfa_pkg::OP_LT, 2, 4, 1, 2, 1, 0, 1, 0);
    add_row(rfa_pkg::OP_GT, 2, 4, 1, 2, 1, 0, 1, 0);
    add_row(OP_SPARE, 5, 7, 3, 9, 1, 0, 1, 0);
    add_row(rfa_pkg::OP_ADD, -32768, -32768, 32767, 32767);
    add_row(rfa_pkg::OP_ADD, -32768, 32767, -32768, 32767);
    add_row(rfa_pkg::OP_SUB, 32767, -32768, -32768, 32767);
    add_row(rfa_pkg::OP_SUB, -5, 0, 0, -32768);
    add_row(rfa_pkg::OP_MUL, 32767, -32768, -32768, -1);
    add_row(rfa_pkg::OP_DIV, -32768, 32767, 32767, -32768);
    add_row(rfa_pkg::OP_DIV, 7, -3, 0, -2);
    add_row(rfa_pkg::OP_EQ, 0, 3, 0, -3);
    add_row(rfa_pkg::OP_EQ, -32768, -32768, -32768, -32768);
    add_row(rfa_pkg::OP_LT, -32768, 1, 32767, 1);
    add_row(rfa_pkg::OP_GT, 0, -4, 0, 9);
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(9);
      r.opcode = ($urandom_range(49) == 0) ? OP_SPARE : 3'($urandom_range(6));
      r.a_num  = rand_part(sel < 5 ? 0 : (sel == 9 ? 1 : 2));
      r.a_den  = rand_part(sel < 5 ? 0 : (sel == 8 ? 1 : 2));
      r.b_num  = rand_part(sel < 5 ? 0 : (sel == 7 ? 1 : 2));
      r.b_den  = rand_part(sel < 5 ? 0 : (sel == 6 ? 1 : 2));
      // give the compares a fair share of equal operands
      if (r.opcode >= rfa_pkg::OP_EQ && $urandom_range(2) == 0) begin
        r.b_num = r.a_num;
        r.b_den = r.a_den;
        if ($urandom_range(1)) begin
          r.b_num = -r.a_num;
          r.b_den = -r.a_den;
        end
      end
      r.typed = 0;
      op_list.push_back(r);
    end
  end

  // ---------------- clock and reset ----------------
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_ch.valid   = 0;
    in_ch.opcode  = rfa_pkg::OP_ADD;
    in_ch.a_num   = 0;
    in_ch.a_den   = 1;
    in_ch.b_num   = 0;
    in_ch.b_den   = 1;
    out_ch.ready  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  // ---------------- input driver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (op_list[next_op].typed)
          pending_results.push_back('{op_list[next_op].num, op_list[next_op].den,
                                      op_list[next_op].cmp});
        else
          pending_results.push_back(fraction_result(op_list[next_op]));
        next_op = next_op + 1;
      end
      // hold the word until it is taken
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (next_op < op_list.size() &&
            ((next_op > 600 && next_op < 800) || $urandom_range(99) >= 24)) begin
          in_ch.valid  <= 1;
          in_ch.opcode <= op_list[next_op].opcode;
          in_ch.a_num  <= op_list[next_op].a_num;
          in_ch.a_den  <= op_list[next_op].a_den;
          in_ch.b_num  <= op_list[next_op].b_num;
          in_ch.b_den  <= op_list[next_op].b_den;
        end else begin
          in_ch.valid <= 0;
        end
      end
      if (next_op >= op_list.size() && op_list.size() > 0) stim_done = 1;
    end
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    fraction_res_t exp_res;
    cycle_count = cycle_count + 1;
    if (rst_n) begin
      out_ch.ready <= (cycle_count > 60000 && cycle_count < 80000) ||
                      ($urandom_range(99) >= 24);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word num=%0d den=%0d cmp=%0b",
                 out_ch.res_num, out_ch.res_den, out_ch.cmp_true);
          error_count = error_count + 1;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_ch.res_num !== exp_res.num) begin
            $error("res_num expected %0d actual %0d", exp_res.num, out_ch.res_num);
            error_count = error_count + 1;
          end
          if (out_ch.res_den !== exp_res.den) begin
            $error("res_den expected %0d actual %0d", exp_res.den, out_ch.res_den);
            error_count = error_count + 1;
          end
          if (out_ch.cmp_true !== exp_res.cmp) begin
            $error("cmp_true expected %0b actual %0b", exp_res.cmp, out_ch.cmp_true);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- end of run ----------------
  initial begin
    next_op     = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    error_count = 0;
    stim_done   = 0;
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rfa_pkg.sv
rtl/core/rfa_in_if.sv
rtl/core/rfa_out_if.sv
rtl/core/rfa_ctrl.sv
rtl/core/rfa_dpath.sv
rtl/core/rational_fraction_alu_core.sv
tb/testbench.sv
